/* hw/rtl/lcdws_pkg.sv */
`default_nettype none

package lcdws_pkg;

    localparam int DISPLAY_COLUMNS_DEF = 16;

    localparam int CNT_W   = 6;
    localparam int KIND_W  = 4;
    localparam int DIGITS  = 10;
    localparam int NUM_W   = 32;
    localparam int ROWS    = 8;

    localparam logic [2:0] OP_RAW_CMD   = 3'd0;
    localparam logic [2:0] OP_RAW_DATA  = 3'd1;
    localparam logic [2:0] OP_SET_CUR   = 3'd2;
    localparam logic [2:0] OP_CHAR_AT   = 3'd3;
    localparam logic [2:0] OP_GLYPH     = 3'd4;
    localparam logic [2:0] OP_NUMBER    = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;

    localparam logic [KIND_W-1:0] K_RAW_CMD  = 4'd0;
    localparam logic [KIND_W-1:0] K_RAW_DATA = 4'd1;
    localparam logic [KIND_W-1:0] K_CURSOR   = 4'd2;
    localparam logic [KIND_W-1:0] K_CURSOR0  = 4'd3;
    localparam logic [KIND_W-1:0] K_GADDR    = 4'd4;
    localparam logic [KIND_W-1:0] K_ROW      = 4'd5;
    localparam logic [KIND_W-1:0] K_HOME     = 4'd6;
    localparam logic [KIND_W-1:0] K_DIGIT    = 4'd7;
    localparam logic [KIND_W-1:0] K_SPACE    = 4'd8;

    localparam logic [7:0] LCD_DDRAM_L0 = 8'h80;
    localparam logic [7:0] LCD_DDRAM_L1 = 8'hC0;
    localparam logic [7:0] LCD_CGRAM    = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef struct packed {
        logic              load;
        logic              bcd_start;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [CNT_W-1:0]  idx;
    } cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [2:0] op;
        logic       line_ok;
        logic       slot_ok;
        logic       bcd_done;
        logic [3:0] digit_count;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/lcdws_datapath.sv */
`default_nettype none

module lcdws_datapath #(
    parameter int DISPLAY_COLUMNS = lcdws_pkg::DISPLAY_COLUMNS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire lcdws_pkg::cmd_t cmd,
    output lcdws_pkg::status_t  sts,
    input  wire  [2:0]          operation,
    input  wire  [7:0]          byte_value,
    input  wire  [7:0]          line,
    input  wire  [7:0]          column,
    input  wire  [7:0]          glyph_slot,
    input  wire  [63:0]         glyph_rows,
    input  wire  [31:0]         number,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic                register_select,
    output logic [7:0]          bus_byte,
    output logic                last_write
);
    import lcdws_pkg::*;

    logic [2:0]       op_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       line_reg;
    logic [7:0]       column_reg;
    logic [7:0]       slot_reg;
    logic [7:0]       rows_reg [ROWS];
    logic [NUM_W-1:0] number_reg;
    logic [NUM_W-1:0] bin_reg;
    logic [3:0]       bcd_reg [DIGITS];
    logic [3:0]       bcd_adj [DIGITS];
    logic             bcd_busy_reg;
    logic [4:0]       step_cnt_reg;

    logic             out_valid_reg;
    logic             rs_reg;
    logic [7:0]       bus_reg;
    logic             last_reg;

    logic             rs_next;
    logic [7:0]       bus_next;
    logic [7:0]       col_clamped;
    logic [7:0]       line_base;
    logic [3:0]       digit_count;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_comb
    begin
        digit_count = 4'd1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                digit_count = 4'(i + 1);
            end
        end
    end

    assign col_clamped = (column_reg >= 8'(DISPLAY_COLUMNS)) ? 8'(DISPLAY_COLUMNS - 1)
                                                            : column_reg;
    assign line_base   = line_reg[0] ? LCD_DDRAM_L1 : LCD_DDRAM_L0;

    always_comb
    begin
        rs_next  = RS_CMD;
        bus_next = byte_reg;
        case (cmd.kind)
            K_RAW_CMD:
            begin
                rs_next  = RS_CMD;
                bus_next = byte_reg;
            end
            K_RAW_DATA:
            begin
                rs_next  = RS_DATA;
                bus_next = byte_reg;
            end
            K_CURSOR:
            begin
                rs_next  = RS_CMD;
                bus_next = line_base + col_clamped;
            end
            K_CURSOR0:
            begin
                rs_next  = RS_CMD;
                bus_next = line_base;
            end
            K_GADDR:
            begin
                rs_next  = RS_CMD;
                bus_next = LCD_CGRAM + {2'b00, slot_reg[2:0], 3'b000};
            end
            K_ROW:
            begin
                rs_next  = RS_DATA;
                bus_next = rows_reg[~cmd.idx[2:0]];
            end
            K_HOME:
            begin
                rs_next  = RS_CMD;
                bus_next = LCD_DDRAM_L0;
            end
            K_DIGIT:
            begin
                rs_next  = RS_DATA;
                bus_next = ASCII_ZERO + {4'b0000, bcd_reg[cmd.idx[3:0]]};
            end
            K_SPACE:
            begin
                rs_next  = RS_DATA;
                bus_next = ASCII_SPACE;
            end
            default:
            begin
                rs_next  = RS_CMD;
                bus_next = byte_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            byte_reg   <= byte_value;
            line_reg   <= line;
            column_reg <= column;
            slot_reg   <= glyph_slot;
            number_reg <= number;
            for (int i = 0; i < ROWS; i++)
            begin
                rows_reg[i] <= glyph_rows[i*8 +: 8];
            end
        end
        if (cmd.bcd_start)
        begin
            bin_reg <= number_reg;
            for (int i = 0; i < DIGITS; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        else if (bcd_busy_reg)
        begin
            bin_reg    <= {bin_reg[NUM_W-2:0], 1'b0};
            bcd_reg[0] <= {bcd_adj[0][2:0], bin_reg[NUM_W-1]};
            for (int i = 1; i < DIGITS; i++)
            begin
                bcd_reg[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
            end
        end
        if (cmd.emit)
        begin
            rs_reg   <= rs_next;
            bus_reg  <= bus_next;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bcd_busy_reg  <= 1'b0;
            step_cnt_reg  <= 5'd0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.bcd_start)
            begin
                bcd_busy_reg <= 1'b1;
                step_cnt_reg <= 5'd0;
            end
            else if (bcd_busy_reg)
            begin
                step_cnt_reg <= step_cnt_reg + 5'd1;
                if (step_cnt_reg == 5'(NUM_W - 1))
                begin
                    bcd_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.op          = op_reg;
    assign sts.line_ok     = (line_reg[7:1] == 7'd0);
    assign sts.slot_ok     = (slot_reg[7:3] == 5'd0);
    assign sts.bcd_done    = !bcd_busy_reg;
    assign sts.digit_count = digit_count;

    assign out_valid       = out_valid_reg;
    assign register_select = rs_reg;
    assign bus_byte        = bus_reg;
    assign last_write      = last_reg;

`ifndef SYNTHESIS
    a_emit_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !bcd_busy_reg)
        else $error("write issued during BCD conversion");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == K_DIGIT) |-> ({2'b00, digit_count} > cmd.idx))
        else $error("digit index beyond number length");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.emit)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/lcdws_controller.sv */
`default_nettype none

module lcdws_controller #(
    parameter int DISPLAY_COLUMNS = lcdws_pkg::DISPLAY_COLUMNS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire lcdws_pkg::status_t sts,
    output lcdws_pkg::cmd_t     cmd
);
    import lcdws_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_CONV = 3'd2;
    localparam logic [2:0] S_HEAD = 3'd3;
    localparam logic [2:0] S_BODY = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;

    logic [2:0]        state_reg,     state_next;
    logic [KIND_W-1:0] head_kind_reg, head_kind_next;
    logic [KIND_W-1:0] body_kind_reg, body_kind_next;
    logic              body_en_reg,   body_en_next;
    logic              tail_en_reg,   tail_en_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        head_kind_next = head_kind_reg;
        body_kind_next = body_kind_reg;
        body_en_next   = body_en_reg;
        tail_en_next   = tail_en_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                body_en_next = 1'b0;
                tail_en_next = 1'b0;
                cnt_next     = '0;
                state_next   = S_IDLE;
                case (sts.op)
                    OP_RAW_CMD:
                    begin
                        head_kind_next = K_RAW_CMD;
                        state_next     = S_HEAD;
                    end
                    OP_RAW_DATA:
                    begin
                        head_kind_next = K_RAW_DATA;
                        state_next     = S_HEAD;
                    end
                    OP_SET_CUR:
                    begin
                        head_kind_next = K_CURSOR;
                        state_next     = sts.line_ok ? S_HEAD : S_IDLE;
                    end
                    OP_CHAR_AT:
                    begin
                        head_kind_next = K_CURSOR;
                        body_kind_next = K_RAW_DATA;
                        body_en_next   = 1'b1;
                        state_next     = sts.line_ok ? S_HEAD : S_BODY;
                    end
                    OP_GLYPH:
                    begin
                        head_kind_next = K_GADDR;
                        body_kind_next = K_ROW;
                        body_en_next   = 1'b1;
                        tail_en_next   = 1'b1;
                        cnt_next       = CNT_W'(ROWS - 1);
                        state_next     = sts.slot_ok ? S_HEAD : S_IDLE;
                    end
                    OP_NUMBER:
                    begin
                        body_kind_next = K_DIGIT;
                        body_en_next   = 1'b1;
                        cmd.bcd_start  = 1'b1;
                        state_next     = S_CONV;
                    end
                    OP_CLEAR:
                    begin
                        head_kind_next = K_CURSOR0;
                        body_kind_next = K_SPACE;
                        body_en_next   = 1'b1;
                        cnt_next       = CNT_W'(DISPLAY_COLUMNS - 1);
                        state_next     = sts.line_ok ? S_HEAD : S_BODY;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CONV:
            begin
                if (sts.bcd_done)
                begin
                    cnt_next   = CNT_W'(sts.digit_count) - CNT_W'(1);
                    state_next = S_BODY;
                end
            end
            S_HEAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = head_kind_reg;
                    cmd.last = !body_en_reg && !tail_en_reg;
                    if (body_en_reg)
                    begin
                        state_next = S_BODY;
                    end
                    else if (tail_en_reg)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BODY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = body_kind_reg;
                    cmd.idx  = cnt_reg;
                    cmd.last = (cnt_reg == '0) && !tail_en_reg;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        state_next = tail_en_reg ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = K_HOME;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_kind_reg <= K_RAW_CMD;
            body_kind_reg <= K_RAW_DATA;
            body_en_reg   <= 1'b0;
            tail_en_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_kind_reg <= head_kind_next;
            body_kind_reg <= body_kind_next;
            body_en_reg   <= body_en_next;
            tail_en_reg   <= tail_en_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/char_lcd_write_sequencer_top.sv */
`default_nettype none

// Character LCD write sequencer.
// Input channel (in_valid/in_ready) takes one request beat: an operation and
// its operands. Output channel (out_valid/out_ready) gives one bus write per
// beat: register_select, bus_byte, and last_write on the final write of the
// request. A request that needs no write produces no beat at all.
// Timing: a request is taken in idle, decoded in the next cycle, then writes
// leave at one per cycle while the receiver takes them. A clear line request
// gives up to DISPLAY_COLUMNS + 1 writes, and a save glyph request 10.
// Print number first runs the binary-to-BCD shifter, one bit per cycle over
// all 32 bits of the number, then sizes the digits and writes them.
// The next request is taken once the last write of the current one is loaded
// into the output register.
// A stalled receiver holds the output register and pauses the sequencer;
// nothing is dropped. Reset clears the state machine and the output valid,
// and the block comes out of reset idle and ready.

module char_lcd_write_sequencer_top #(
    parameter int DISPLAY_COLUMNS = lcdws_pkg::DISPLAY_COLUMNS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [2:0]  operation,
    input  wire  [7:0]  byte_value,
    input  wire  [7:0]  line,
    input  wire  [7:0]  column,
    input  wire  [7:0]  glyph_slot,
    input  wire  [63:0] glyph_rows,
    input  wire  [31:0] number,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        register_select,
    output logic [7:0]  bus_byte,
    output logic        last_write
);
    import lcdws_pkg::*;

    cmd_t    cmd;
    status_t sts;

    lcdws_controller #(
        .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcdws_datapath #(
        .DISPLAY_COLUMNS(DISPLAY_COLUMNS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (operation),
        .byte_value      (byte_value),
        .line            (line),
        .column          (column),
        .glyph_slot      (glyph_slot),
        .glyph_rows      (glyph_rows),
        .number          (number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .register_select (register_select),
        .bus_byte        (bus_byte),
        .last_write      (last_write)
    );

endmodule

`default_nettype wire

/* tb/sv/lcd_write_checker.sv */
`timescale 1ns / 1ps

module lcd_write_checker #(
    parameter int COLUMNS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire  [2:0]  operation,
    input  wire  [7:0]  byte_value,
    input  wire  [7:0]  line,
    input  wire  [7:0]  column,
    input  wire  [7:0]  glyph_slot,
    input  wire  [63:0] glyph_rows,
    input  wire  [31:0] number,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire         register_select,
    input  wire  [7:0]  bus_byte,
    input  wire         last_write,
    output int          fail_count,
    output int          pending
);
    import lcdws_pkg::*;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } bus_write_t;

    bus_write_t expected_writes[$];
    bus_write_t want;
    int         mismatches = 0;

    assign fail_count = mismatches;
    assign pending    = expected_writes.size();

    function automatic void queue_write(input logic rs, input logic [7:0] data);
        bus_write_t w;
        w.rs   = rs;
        w.data = data;
        w.last = 1'b0;
        expected_writes.push_back(w);
    endfunction

    function automatic void queue_cursor(input logic [7:0] ln, input logic [7:0] col);
        logic [7:0] c;
        c = (col > COLUMNS - 1) ? 8'(COLUMNS - 1) : col;
        if (ln == 8'd0)
            queue_write(RS_CMD, LCD_DDRAM_L0 + c);
        else if (ln == 8'd1)
            queue_write(RS_CMD, LCD_DDRAM_L1 + c);
    endfunction

    function automatic void predict_bus_writes(
        input logic [2:0]  op,
        input logic [7:0]  bv,
        input logic [7:0]  ln,
        input logic [7:0]  col,
        input logic [7:0]  slot,
        input logic [63:0] rows,
        input logic [31:0] num
    );
        int         first;
        logic [31:0] rest;
        logic [7:0] digits[$];
        bus_write_t tail;
        first = expected_writes.size();
        case (op)
            OP_RAW_CMD:  queue_write(RS_CMD, bv);
            OP_RAW_DATA: queue_write(RS_DATA, bv);
            OP_SET_CUR:  queue_cursor(ln, col);
            OP_CHAR_AT:
            begin
                queue_cursor(ln, col);
                queue_write(RS_DATA, bv);
            end
            OP_GLYPH:
            begin
                if (slot < 8)
                begin
                    queue_write(RS_CMD, LCD_CGRAM + {slot[4:0], 3'b000});
                    for (int i = 0; i < ROWS; i++)
                        queue_write(RS_DATA, rows[8*i +: 8]);
                    queue_write(RS_CMD, LCD_DDRAM_L0);
                end
            end
            OP_NUMBER:
            begin
                rest = num;
                do
                begin
                    digits.push_front(ASCII_ZERO + 8'(rest % 10));
                    rest = rest / 10;
                end
                while (rest != 0);
                foreach (digits[i])
                    queue_write(RS_DATA, digits[i]);
            end
            OP_CLEAR:
            begin
                queue_cursor(ln, 8'd0);
                for (int i = 0; i < COLUMNS; i++)
                    queue_write(RS_DATA, ASCII_SPACE);
            end
            default: ;
        endcase
        if (expected_writes.size() > first)
        begin
            tail = expected_writes.pop_back();
            tail.last = 1'b1;
            expected_writes.push_back(tail);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_bus_writes(operation, byte_value, line, column, glyph_slot,
                                   glyph_rows, number);
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected beat: rs=%0d byte=%02h last=%0d",
                                 register_select, bus_byte, last_write);
                    mismatches++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (want.rs !== register_select || want.data !== bus_byte ||
                        want.last !== last_write)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected %0d %02h %0d, got %0d %02h %0d",
                                     want.rs, want.data, want.last,
                                     register_select, bus_byte, last_write);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lcdws_pkg::*;

    localparam int         COLUMNS        = 16;
    localparam logic [2:0] OP_UNUSED      = 3'd7;
    localparam int         HOLD_AT        = 2500;
    localparam int         HOLD_LEN       = 400;
    localparam int         QUIET_FROM     = 800;
    localparam int         QUIET_TO       = 1800;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_ITEMS   = 395;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [7:0]  byte_value;
    logic [7:0]  line;
    logic [7:0]  column;
    logic [7:0]  glyph_slot;
    logic [63:0] glyph_rows;
    logic [31:0] number;
    logic        out_valid;
    logic        out_ready;
    logic        register_select;
    logic [7:0]  bus_byte;
    logic        last_write;
    int          fail_count;
    int          pending;
    int          cyc = 0;
    logic        quiet;

    char_lcd_write_sequencer_top #(
        .DISPLAY_COLUMNS(COLUMNS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .byte_value(byte_value),
        .line(line),
        .column(column),
        .glyph_slot(glyph_slot),
        .glyph_rows(glyph_rows),
        .number(number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .register_select(register_select),
        .bus_byte(bus_byte),
        .last_write(last_write)
    );

    lcd_write_checker #(
        .COLUMNS(COLUMNS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .byte_value(byte_value),
        .line(line),
        .column(column),
        .glyph_slot(glyph_slot),
        .glyph_rows(glyph_rows),
        .number(number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .register_select(register_select),
        .bus_byte(bus_byte),
        .last_write(last_write),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    task automatic offer(
        input logic [2:0]  op,
        input logic [7:0]  bv,
        input logic [7:0]  ln,
        input logic [7:0]  col,
        input logic [7:0]  slot,
        input logic [63:0] rows,
        input logic [31:0] num
    );
        while (!quiet && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        byte_value <= bv;
        line       <= ln;
        column     <= col;
        glyph_slot <= slot;
        glyph_rows <= rows;
        number     <= num;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver: random stalls, always ready in the quiet window, one long hold-off to back the block up
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (cyc == HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge clk);
            end
            else if (quiet)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 17);
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          produced;
        logic [2:0]  r_op;
        logic [7:0]  r_bv;
        logic [7:0]  r_line;
        logic [7:0]  r_col;
        logic [7:0]  r_slot;
        logic [63:0] r_rows;
        logic [31:0] r_num;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_RAW_CMD;
        byte_value = 8'd0;
        line       = 8'd0;
        column     = 8'd0;
        glyph_slot = 8'd0;
        glyph_rows = 64'd0;
        number     = 32'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(OP_RAW_CMD,  8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_RAW_CMD,  8'hFF, 8'hFF,  8'hFF,  8'hFF,  '1,    '1);
        offer(OP_RAW_DATA, 8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_RAW_DATA, 8'hFF, 8'd3,   8'd9,   8'd2,   64'd5, 32'd7);
        offer(OP_SET_CUR,  8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_SET_CUR,  8'h00, 8'd1,   8'd15,  8'd0,   64'd0, 32'd0);
        offer(OP_SET_CUR,  8'h00, 8'd1,   8'd255, 8'd0,   64'd0, 32'd0);
        offer(OP_SET_CUR,  8'h00, 8'd0,   8'd16,  8'd0,   64'd0, 32'd0);
        offer(OP_SET_CUR,  8'h00, 8'd2,   8'd3,   8'd0,   64'd0, 32'd0);
        offer(OP_SET_CUR,  8'h00, 8'd255, 8'd3,   8'd0,   64'd0, 32'd0);
        offer(OP_CHAR_AT,  8'hAA, 8'd0,   8'd16,  8'd0,   64'd0, 32'd0);
        offer(OP_CHAR_AT,  8'h55, 8'd1,   8'd7,   8'd0,   64'd0, 32'd0);
        offer(OP_CHAR_AT,  8'h41, 8'd7,   8'd7,   8'd0,   64'd0, 32'd0);
        offer(OP_GLYPH,    8'h00, 8'd0,   8'd0,   8'd0,   '1,    32'd0);
        offer(OP_GLYPH,    8'h00, 8'd0,   8'd0,   8'd7,   64'h0123_4567_89AB_CDEF, 32'd0);
        offer(OP_GLYPH,    8'h00, 8'd0,   8'd0,   8'd8,   '1,    32'd0);
        offer(OP_GLYPH,    8'h00, 8'd0,   8'd0,   8'd255, '1,    32'd0);
        offer(OP_NUMBER,   8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_NUMBER,   8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'hFFFF_FFFF);
        offer(OP_NUMBER,   8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd9);
        offer(OP_NUMBER,   8'h00, 8'd0,   8'd0,   8'd0,   64'd0, 32'd1_000_000_000);
        offer(OP_CLEAR,    8'h00, 8'd0,   8'd200, 8'd0,   64'd0, 32'd0);
        offer(OP_CLEAR,    8'h00, 8'd1,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_CLEAR,    8'h00, 8'd3,   8'd0,   8'd0,   64'd0, 32'd0);
        offer(OP_UNUSED,   8'h12, 8'd0,   8'd5,   8'd1,   64'd9, 32'd3);

        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            r_op   = ($urandom_range(0, 99) < 95) ? 3'($urandom_range(0, 6)) : OP_UNUSED;
            r_bv   = 8'($urandom);
            r_line = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            r_col  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            r_slot = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            r_rows = {$urandom, $urandom};
            r_num  = ($urandom_range(0, 3) == 0) ? $urandom
                                                 : ($urandom >> $urandom_range(0, 31));
            offer(r_op, r_bv, r_line, r_col, r_slot, r_rows, r_num);
            produced++;
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (60) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
